// File: rtl/core/rdc_pkg.sv
// rdc_pkg: shared constants, types and the digit-to-ASCII function of the
// radix digit converter. No dependencies.
`default_nettype none
package rdc_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int REQ_VALUE_W    = 32;
   localparam int RADIX_W        = 5;
   localparam int CHAR_W         = 7;
   localparam int DIGIT_W        = 4;
   localparam int STEP_BITS      = 8;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
   localparam logic [DIGIT_W-1:0] DEC_LIMIT = 4'd10;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;
   localparam logic [CHAR_W-1:0]  CHAR_ERR  = 7'h00;

   typedef enum logic [1:0] {
      KIND_NUM,
      KIND_ZERO,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [RADIX_W-1:0]  radix;
   } entry_ctl_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DEC_LIMIT) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else begin
         c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/rdc_front.sv
// rdc_front: accepts request words, classifies them (bad radix, zero, number)
// and holds them in a short queue for the back end. Depends on rdc_pkg.
`default_nettype none
module rdc_front #(
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_push,
   output logic                             req_full,
   input  wire [rdc_pkg::REQ_VALUE_W-1:0]   req_value,
   input  wire [rdc_pkg::RADIX_W-1:0]       req_radix,
   output logic                             q_valid,
   input  wire                              q_take,
   output rdc_pkg::entry_ctl_type           q_ctl,
   output logic [VALUE_BITS-1:0]            q_value
);
   import rdc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_ctl_type           ctl_mem_ff [QUEUE_DEPTH];
   logic [VALUE_BITS-1:0]   val_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic                    push_ok;
   logic                    take_ok;
   logic [VALUE_BITS-1:0]   value_trim;
   entry_ctl_type           new_ctl;

   assign req_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign push_ok  = req_push && !req_full;
   assign take_ok  = q_take && q_valid;
   assign q_ctl    = ctl_mem_ff[rd_ptr_ff];
   assign q_value  = val_mem_ff[rd_ptr_ff];

   always_comb begin
      value_trim    = VALUE_BITS'(req_value);
      new_ctl.radix = req_radix;
      if ((req_radix < RADIX_MIN) || (req_radix > RADIX_MAX)) begin
         new_ctl.kind = KIND_BAD;
      end else if (value_trim == '0) begin
         new_ctl.kind = KIND_ZERO;
      end else begin
         new_ctl.kind = KIND_NUM;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !take_ok) begin
         count_in = count_ff + 1'b1;
      end else if (take_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         ctl_mem_ff[wr_ptr_ff] <= new_ctl;
         val_mem_ff[wr_ptr_ff] <= value_trim;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/rdc_back.sv
// rdc_back: repeated division by the radix, eight dividend bits per cycle,
// digit stack for reversal and the result output register. Depends on rdc_pkg.
`default_nettype none
module rdc_back #(
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              q_valid,
   output logic                             q_take,
   input  rdc_pkg::entry_ctl_type           q_ctl,
   input  wire [VALUE_BITS-1:0]             q_value,
   output logic                             rsp_empty,
   input  wire                              rsp_pop,
   output logic [rdc_pkg::CHAR_W-1:0]       rsp_digit_char,
   output logic                             rsp_last,
   output logic                             rsp_bad_radix
);
   import rdc_pkg::*;

   localparam int NCHUNK = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PW     = NCHUNK * STEP_BITS;
   localparam int MAXD   = VALUE_BITS;
   localparam int CNT_W  = $clog2(MAXD + 1);
   localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [PW-1:0]           val_ff, val_in;
   logic [RADIX_W-1:0]      radix_ff, radix_in;
   logic                    bad_ff, bad_in;
   logic [CHK_W-1:0]        chunk_ff, chunk_in;
   logic [DIGIT_W-1:0]      rem_ff, rem_in;
   logic [DIGIT_W-1:0]      stack_ff [MAXD];
   logic [DIGIT_W-1:0]      stack_in [MAXD];
   logic [CNT_W-1:0]        depth_ff, depth_in;
   logic                    out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]       out_char_ff, out_char_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_bad_ff, out_bad_in;

   logic [STEP_BITS-1:0]    div_quot;
   logic [DIGIT_W-1:0]      div_rem;
   logic [PW-1:0]           val_shift;
   logic                    last_chunk;
   logic                    out_free;
   logic                    do_push;
   logic                    do_pop;
   logic [DIGIT_W-1:0]      push_digit;

   // one restoring division step per dividend bit; remainder stays below radix
   always_comb begin
      logic [DIGIT_W-1:0]   r;
      logic [RADIX_W-1:0]   t;
      r        = rem_ff;
      div_quot = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         t = {r, val_ff[PW - STEP_BITS + i]};
         if (t >= radix_ff) begin
            t           = t - radix_ff;
            div_quot[i] = 1'b1;
         end
         r = t[DIGIT_W-1:0];
      end
      div_rem = r;
   end

   assign val_shift  = PW'({val_ff, div_quot});
   assign last_chunk = (chunk_ff == CHK_W'(NCHUNK - 1));
   assign out_free   = !out_valid_ff || rsp_pop;

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      radix_in     = radix_ff;
      bad_in       = bad_ff;
      chunk_in     = chunk_ff;
      rem_in       = rem_ff;
      depth_in     = depth_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_bad_in   = out_bad_ff;
      q_take       = 1'b0;
      do_push      = 1'b0;
      do_pop       = 1'b0;
      push_digit   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_take   = 1'b1;
               val_in   = PW'(q_value);
               radix_in = q_ctl.radix;
               bad_in   = (q_ctl.kind == KIND_BAD);
               chunk_in = '0;
               rem_in   = '0;
               if (q_ctl.kind == KIND_NUM) begin
                  state_in = ST_DIV;
               end else begin
                  do_push  = 1'b1;
                  depth_in = depth_ff + 1'b1;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIV: begin
            val_in = val_shift;
            if (last_chunk) begin
               do_push    = 1'b1;
               push_digit = div_rem;
               depth_in   = depth_ff + 1'b1;
               rem_in     = '0;
               chunk_in   = '0;
               if (val_shift == '0) begin
                  state_in = ST_EMIT;
               end
            end else begin
               rem_in   = div_rem;
               chunk_in = chunk_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               do_pop       = 1'b1;
               out_valid_in = 1'b1;
               out_char_in  = bad_ff ? CHAR_ERR : digit_to_char(stack_ff[0]);
               out_last_in  = (depth_ff == CNT_W'(1));
               out_bad_in   = bad_ff;
               depth_in     = depth_ff - 1'b1;
               if (depth_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // digit stack: push enters at the bottom tap, pop drains from it
   always_comb begin
      for (int i = 0; i < MAXD; i++) begin
         stack_in[i] = stack_ff[i];
      end
      if (do_push) begin
         stack_in[0] = push_digit;
         for (int i = 1; i < MAXD; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
      end else if (do_pop) begin
         for (int i = 0; i < MAXD - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
         stack_in[MAXD-1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chunk_ff     <= '0;
         depth_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chunk_ff     <= chunk_in;
         depth_ff     <= depth_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      radix_ff    <= radix_in;
      bad_ff      <= bad_in;
      rem_ff      <= rem_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_bad_ff  <= out_bad_in;
      for (int i = 0; i < MAXD; i++) begin
         stack_ff[i] <= stack_in[i];
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_bad_radix  = out_bad_ff;

endmodule
`default_nettype wire

// File: rtl/core/radix_digit_converter.sv
// radix_digit_converter: top level, front queue plus division back end.
// Depends on rdc_pkg, rdc_front, rdc_back.
//
//  channel   direction  handshake        word
//  req_      in         push / full      value, radix
//  rsp_      out        empty / pop      digit_char, last, bad_radix
//
// In the back end a number word is taken from the queue, then divided by the
// radix once per digit, 8 dividend bits a cycle over C = ceil(VALUE_BITS/8)
// chunks, and its N digits are emitted from the stack as the output register
// frees; zero and bad-radix words are taken and emitted as one digit word.
// Reset is synchronous and clears queue, state machine and output valid.
// A two-word queue lets requests land while the back end divides or waits on pop.
`default_nettype none
module radix_digit_converter #(
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_push,
   output logic                             req_full,
   input  wire [rdc_pkg::REQ_VALUE_W-1:0]   req_value,
   input  wire [rdc_pkg::RADIX_W-1:0]       req_radix,
   output logic                             rsp_empty,
   input  wire                              rsp_pop,
   output logic [rdc_pkg::CHAR_W-1:0]       rsp_digit_char,
   output logic                             rsp_last,
   output logic                             rsp_bad_radix
);
   import rdc_pkg::*;

   logic                    q_valid;
   logic                    q_take;
   entry_ctl_type           q_ctl;
   logic [VALUE_BITS-1:0]   q_value;

   rdc_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .req_radix (req_radix),
      .q_valid   (q_valid),
      .q_take    (q_take),
      .q_ctl     (q_ctl),
      .q_value   (q_value)
   );

   rdc_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_take         (q_take),
      .q_ctl          (q_ctl),
      .q_value        (q_value),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_bad_radix  (rsp_bad_radix)
   );

endmodule
`default_nettype wire

// File: tb/radix_digit_converter_test.sv
// radix_digit_converter_test: self-checking bench for radix_digit_converter.
// Random and directed words in, digit words checked against a local predictor.
// Depends on rdc_pkg and the radix_digit_converter RTL.
`timescale 1ns / 100ps
module radix_digit_converter_test;
   import rdc_pkg::*;

   localparam int RANDOM_WORDS = 98;
   localparam int TAIL_CYCLES  = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT      = 60;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SHOWN_ERRORS = 10;

   typedef struct packed {
      logic [REQ_VALUE_W-1:0] value;
      logic [RADIX_W-1:0]     radix;
   } number_word_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              bad;
   } digit_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [REQ_VALUE_W-1:0] req_value = '0;
   logic [RADIX_W-1:0]     req_radix = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [CHAR_W-1:0]      rsp_digit_char;
   logic                   rsp_last;
   logic                   rsp_bad_radix;

   number_word_type numbers_pending[$];
   digit_word_type  digits_due[$];

   int words_sent = 0;
   int words_total = 0;
   int digits_seen = 0;
   int bad_words = 0;
   int zero_words = 0;
   int error_count = 0;
   int full_cycles = 0;
   int send_wait = 0;
   int recv_wait = 0;
   int hold_left = 0;
   bit hold_done = 0;
   bit send_calm = 0;
   bit recv_calm = 0;

   radix_digit_converter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_bad_radix  (rsp_bad_radix)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Repeated division, digits queued most significant first.
   function automatic void queue_digits(input logic [REQ_VALUE_W-1:0] value,
                                        input logic [RADIX_W-1:0] radix);
      logic [CHAR_W-1:0] rev [0:REQ_VALUE_W-1];
      int unsigned       v;
      int unsigned       b;
      int unsigned       d;
      int                n;
      digit_word_type    w;
      v = value;
      b = 32'(radix);
      n = 0;
      if (radix < RADIX_MIN || radix > RADIX_MAX) begin
         w = '{ch: CHAR_ERR, last: 1'b1, bad: 1'b1};
         digits_due.push_back(w);
         bad_words++;
         return;
      end
      if (v == 0) begin
         w = '{ch: CHAR_ZERO, last: 1'b1, bad: 1'b0};
         digits_due.push_back(w);
         zero_words++;
         return;
      end
      while (v != 0) begin
         d = v % b;
         v = v / b;
         if (d < DEC_LIMIT) begin
            rev[n] = CHAR_ZERO + CHAR_W'(d);
         end else begin
            rev[n] = CHAR_A + CHAR_W'(d - DEC_LIMIT);
         end
         n++;
      end
      for (int k = n - 1; k >= 0; k--) begin
         w = '{ch: rev[k], last: (k == 0), bad: 1'b0};
         digits_due.push_back(w);
      end
   endfunction

   task automatic add_number(input logic [REQ_VALUE_W-1:0] value,
                             input logic [RADIX_W-1:0] radix);
      number_word_type w;
      w.value = value;
      w.radix = radix;
      numbers_pending.push_back(w);
   endtask

   // Driver
   always @(posedge clock) begin
      logic            fired;
      logic            push_next;
      number_word_type w;
      if (reset) begin
         req_push <= 1'b0;
         send_wait = 0;
      end else begin
         fired = req_push && !req_full;
         push_next = 1'b0;
         if (req_push && req_full) begin
            full_cycles++;
         end
         if (fired) begin
            queue_digits(req_value, req_radix);
            words_sent++;
            if ($urandom_range(0, 11) == 0) begin
               send_calm = !send_calm;
            end
            send_wait = send_calm ? 0 : $urandom_range(0, 17);
         end
         if (req_push && !fired) begin
            push_next = 1'b1;
         end else if (send_wait != 0) begin
            send_wait--;
         end else if (numbers_pending.size() != 0) begin
            w = numbers_pending.pop_front();
            req_value <= w.value;
            req_radix <= w.radix;
            push_next = 1'b1;
         end
         req_push <= push_next;
      end
   end

   // Long receiver stall so the input side backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && digits_seen >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor
   always @(posedge clock) begin
      digit_word_type w;
      if (reset) begin
         rsp_pop <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (digits_due.size() == 0) begin
               error_count++;
               if (error_count <= SHOWN_ERRORS) begin
                  $display("ERROR: unexpected digit word char %h last %b bad %b",
                           rsp_digit_char, rsp_last, rsp_bad_radix);
               end
            end else begin
               w = digits_due.pop_front();
               if (rsp_digit_char !== w.ch || rsp_last !== w.last
                   || rsp_bad_radix !== w.bad) begin
                  error_count++;
                  if (error_count <= SHOWN_ERRORS) begin
                     $display("ERROR: digit %0d: expected char %h last %b bad %b, got %h %b %b",
                              digits_seen, w.ch, w.last, w.bad,
                              rsp_digit_char, rsp_last, rsp_bad_radix);
                  end
               end
            end
            digits_seen <= digits_seen + 1;
            if ($urandom_range(0, 11) == 0) begin
               recv_calm = !recv_calm;
            end
            recv_wait = recv_calm ? 0 : $urandom_range(0, 17);
         end
         if (hold_left != 0) begin
            rsp_pop <= 1'b0;
         end else if (recv_wait != 0) begin
            recv_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Timeout
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
      $display("** radix_digit_converter: FAILED **");
      $finish;
   end

   initial begin
      logic [REQ_VALUE_W-1:0] v;
      logic [RADIX_W-1:0]     r;

      add_number(32'd0, 5'd2);
      add_number(32'd0, 5'd10);
      add_number(32'd0, 5'd16);
      add_number(32'hFFFF_FFFF, 5'd2);
      add_number(32'hFFFF_FFFF, 5'd16);
      add_number(32'hFFFF_FFFF, 5'd10);
      add_number(32'hFFFF_FFFF, 5'd3);
      add_number(32'h8000_0000, 5'd2);
      add_number(32'd1, 5'd2);
      add_number(32'd10, 5'd16);
      add_number(32'd15, 5'd16);
      add_number(32'd255, 5'd16);
      add_number(32'd16, 5'd16);
      add_number(32'd8, 5'd8);
      add_number(32'd12, 5'd13);
      add_number(32'hABCD_EF01, 5'd16);
      add_number(32'd123456789, 5'd7);
      add_number($urandom, 5'd0);
      add_number($urandom, 5'd1);
      add_number($urandom, 5'd17);
      add_number(32'hFFFF_FFFF, 5'd31);
      add_number(32'd0, 5'd0);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 255);
            2: v = 32'hFFFF_FFFF >> $urandom_range(0, 31);
            3: v = 32'd1 << $urandom_range(0, 31);
            default: v = $urandom ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
         endcase
         if ($urandom_range(0, 9) == 0) begin
            r = RADIX_W'($urandom_range(0, 16));
            if (r >= 2) begin
               r = r + 5'd15;
            end
         end else begin
            r = RADIX_W'($urandom_range(2, 16));
         end
         add_number(v, r);
      end
      words_total = numbers_pending.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (words_sent < words_total || digits_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Converted %0d words into %0d digit words (%0d bad radix, %0d zero).",
               words_sent, digits_seen, bad_words, zero_words);
      $display("Input held off by full for %0d cycles; %0d errors.",
               full_cycles, error_count);
      if (error_count == 0 && digits_due.size() == 0) begin
         $display("** radix_digit_converter: PASSED **");
      end else begin
         $display("** radix_digit_converter: FAILED **");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/rdc_pkg.sv
rtl/core/rdc_front.sv
rtl/core/rdc_back.sv
rtl/core/radix_digit_converter.sv
tb/radix_digit_converter_test.sv
